// ===== rtl/btlv_pkg.sv =====
// Package for the BER-TLV tag search block.
// Holds the parser phase codes and the beat types shared by the parser and the top level.
// No dependencies.
package btlv_pkg;

   localparam int PHASE_W = 3;

   localparam logic [PHASE_W-1:0] PH_TAG_FIRST = 3'd0;
   localparam logic [PHASE_W-1:0] PH_TAG_MORE  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEN_FIRST = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LEN_MORE  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_VALUE     = 3'd4;

   localparam logic [7:0] PAD_ZERO     = 8'h00;
   localparam logic [7:0] PAD_ONES     = 8'hff;
   localparam logic [4:0] TAG_EXT_CODE = 5'h1f;

   localparam int CFG_W = 32;
   localparam int LEN_W = 32;
   localparam int CNT_W = 7;

   // one input byte held in the input register
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } in_beat_type;

   // what the parser returns for a byte it consumes
   typedef struct packed {
      logic step;    // byte consumed this cycle
      logic last;    // byte closed the message
      logic found;   // sticky match flag including this byte
   } parse_stat_type;

endpackage

// ===== rtl/btlv_parser.sv =====
// BER-TLV parser: phase, tag shift register, length and value counters, found flag.
// Consumes one byte per step; depends on btlv_pkg.
module btlv_parser #(
   parameter int TAG_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  btlv_pkg::in_beat_type       beat,
   input  logic [btlv_pkg::CFG_W-1:0]  tag_to_find,
   output btlv_pkg::parse_stat_type    stat
);
   import btlv_pkg::*;

   localparam int CMP_W = (TAG_BITS > CFG_W) ? TAG_BITS : CFG_W;

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [TAG_BITS-1:0] tag_accum_ff, tag_accum_in;
   logic [CNT_W-1:0]    len_left_ff, len_left_in;
   logic [LEN_W-1:0]    len_accum_ff, len_accum_in;
   logic [LEN_W-1:0]    value_left_ff, value_left_in;
   logic                found_ff, found_in;

   logic [7:0]          b;
   logic [TAG_BITS-1:0] tag_shift;
   logic [LEN_W-1:0]    len_shift;
   logic [LEN_W-1:0]    value_dec;
   logic [CNT_W-1:0]    len_dec;
   logic                tag_match;

   assign b         = beat.data_byte;
   assign tag_shift = (tag_accum_ff << 8) | TAG_BITS'(b);
   assign len_shift = {len_accum_ff[LEN_W-9:0], b};
   assign value_dec = value_left_ff - LEN_W'(1);
   assign len_dec   = len_left_ff - CNT_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      tag_accum_in  = tag_accum_ff;
      len_left_in   = len_left_ff;
      len_accum_in  = len_accum_ff;
      value_left_in = value_left_ff;
      found_in      = found_ff;
      tag_match     = 1'b0;

      case (phase_ff)
         PH_TAG_MORE: begin
            tag_accum_in = tag_shift;
            if (!b[7]) begin
               tag_match = 1'b1;
               phase_in  = PH_LEN_FIRST;
            end
         end
         PH_LEN_FIRST: begin
            if (b[7]) begin
               len_accum_in = '0;
               len_left_in  = b[6:0];
               if (b[6:0] == '0) begin
                  value_left_in = '0;
                  phase_in      = PH_TAG_FIRST;
               end else begin
                  phase_in = PH_LEN_MORE;
               end
            end else begin
               value_left_in = LEN_W'(b);
               phase_in      = (b == '0) ? PH_TAG_FIRST : PH_VALUE;
            end
         end
         PH_LEN_MORE: begin
            len_accum_in = len_shift;
            len_left_in  = len_dec;
            if (len_dec == '0) begin
               value_left_in = len_shift;
               phase_in      = (len_shift == '0) ? PH_TAG_FIRST : PH_VALUE;
            end
         end
         PH_VALUE: begin
            value_left_in = value_dec;
            if (value_dec == '0)
               phase_in = PH_TAG_FIRST;
         end
         default: begin
            // padding bytes before a tag are dropped
            if (b != PAD_ZERO && b != PAD_ONES) begin
               tag_accum_in = TAG_BITS'(b);
               if (b[4:0] == TAG_EXT_CODE) begin
                  phase_in = PH_TAG_MORE;
               end else begin
                  tag_match = 1'b1;
                  phase_in  = PH_LEN_FIRST;
               end
            end
         end
      endcase

      if (tag_match && (CMP_W'(tag_accum_in) == CMP_W'(tag_to_find)))
         found_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && beat.last_byte)) begin
         phase_ff      <= PH_TAG_FIRST;
         tag_accum_ff  <= '0;
         len_left_ff   <= '0;
         len_accum_ff  <= '0;
         value_left_ff <= '0;
         found_ff      <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         tag_accum_ff  <= tag_accum_in;
         len_left_ff   <= len_left_in;
         len_accum_ff  <= len_accum_in;
         value_left_ff <= value_left_in;
         found_ff      <= found_in;
      end
   end

   assign stat.step  = step;
   assign stat.last  = beat.last_byte;
   assign stat.found = found_in;

endmodule

// ===== rtl/ber_tlv_tag_search.sv =====
// Top level of the BER-TLV tag search: input register, parser, result register, tag register.
// A last byte's result is registered in the result register as the parser consumes it.
// Throughput: one byte per cycle; a last byte waits in the input register only while
// an earlier result still waits to be taken at the result register.
// Reset (synchronous): parser state, found flag, both valid bits and tag_to_find clear.
// Depends on btlv_pkg and btlv_parser.
module ber_tlv_tag_search #(
   parameter int TAG_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] data_byte
   input  logic                       req_tlast,   // last_byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [0] found, [7:1] zero
   input  logic                       csr_wr_en,
   input  logic [btlv_pkg::CFG_W-1:0] csr_wr_data
);
   import btlv_pkg::*;

   logic              in_valid_ff, in_valid_in;
   in_beat_type       in_beat_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [CFG_W-1:0]  tag_to_find_ff;
   logic              advance;
   parse_stat_type    stat;

   // a last byte advances only when the result slot is free or being drained
   assign advance    = in_valid_ff &&
                       (!in_beat_ff.last_byte || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = (stat.step && stat.last) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         tag_to_find_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en)
            tag_to_find_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_beat_ff.data_byte <= req_tdata;
         in_beat_ff.last_byte <= req_tlast;
      end
      if (stat.step && stat.last)
         rsp_found_ff <= stat.found;
   end

   btlv_parser #(
      .TAG_BITS (TAG_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .beat        (in_beat_ff),
      .tag_to_find (tag_to_find_ff),
      .stat        (stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_found_ff};

   // a pending result is never overwritten by a new last byte
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && in_beat_ff.last_byte) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // a result appears only after a last byte went through the parser
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_beat_ff.last_byte))
      else $error("result without a last byte");

   // a stalled input beat stays in the input register
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_beat_ff)))
      else $error("stalled input beat lost");

endmodule
